FILE: rtl/core/mpbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mpbm_pkg;
	localparam int ALPHABET_SIZE = 256;
	localparam int CHAR_W = 8;
	localparam int KIND_W = 2;
	localparam int ID_W = 16;
	localparam int STATUS_W = 2;
	localparam int POS_W = 32;
	localparam int TAG_W = ID_W + 1;

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [ID_W-1:0] kw_id_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [TAG_W-1:0] tag_t;

	localparam kind_t KIND_CLEAR = 2'd0;
	localparam kind_t KIND_KEYWORD = 2'd1;
	localparam kind_t KIND_BUILD = 2'd2;
	localparam kind_t KIND_TEXT = 2'd3;

	localparam status_t ST_MATCH = 2'd0;
	localparam status_t ST_OK = 2'd1;
	localparam status_t ST_REJECT = 2'd2;
endpackage
`default_nettype wire

FILE: rtl/core/mpbm_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mpbm_cmd_if;
	import mpbm_pkg::*;
	logic valid;
	logic ready;
	kind_t kind;
	char_t data_byte;
	kw_id_t keyword_id;
	logic first;
	logic last;
	modport source(output valid, kind, data_byte, keyword_id, first, last, input ready);
	modport sink(input valid, kind, data_byte, keyword_id, first, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/mpbm_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mpbm_rsp_if;
	import mpbm_pkg::*;
	logic valid;
	logic ready;
	status_t status;
	kw_id_t match_id;
	pos_t end_position;
	logic final_result;
	modport source(output valid, status, match_id, end_position, final_result, input ready);
	modport sink(input valid, status, match_id, end_position, final_result, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/multi_pattern_byte_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// Aho-Corasick multi-keyword byte matcher. Requests on cmd: clear, keyword byte, build, text
// byte; every request yields one or more responses on rsp, the last one flagged final_result.
// After reset the block runs a clearing pass over the root row before it takes a request; a
// clear request repeats that pass. A keyword byte reads its transition entry and answers;
// when it allocates a node, that node's transition row is zeroed one entry per cycle, then
// linked. A text byte walks its output chain one node at a time, a pace set by the single
// read port of the transition table and the node memories; responses stall the walk when rsp
// is not ready. A build scans the root row, then every byte value of each queued node.
module multi_pattern_byte_matcher #(
	parameter int NODE_POOL = 1024,
	parameter int MAX_KEYWORD_LEN = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	mpbm_cmd_if.sink cmd,
	mpbm_rsp_if.source rsp
);
	import mpbm_pkg::*;

	localparam int NW = $clog2(NODE_POOL);
	localparam int CW = NW + 1;
	localparam int LW = $clog2(MAX_KEYWORD_LEN + 1);
	localparam int TAW = NW + CHAR_W;
	localparam int TDEPTH = NODE_POOL * ALPHABET_SIZE;
	localparam logic [CW-1:0] POOL_CNT = CW'(NODE_POOL);
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_KEYWORD_LEN);
	localparam char_t LAST_CHAR = CHAR_W'(ALPHABET_SIZE - 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_KDAT = 4'd1;
	localparam logic [3:0] S_SWEEP = 4'd2;
	localparam logic [3:0] S_KLINK = 4'd3;
	localparam logic [3:0] S_RESP = 4'd4;
	localparam logic [3:0] S_TDAT = 4'd5;
	localparam logic [3:0] S_TCH = 4'd6;
	localparam logic [3:0] S_FIN = 4'd7;
	localparam logic [3:0] S_R0 = 4'd8;
	localparam logic [3:0] S_POP = 4'd9;
	localparam logic [3:0] S_BU = 4'd10;
	localparam logic [3:0] S_BF = 4'd11;
	localparam logic [3:0] S_BE2 = 4'd12;
	localparam logic [3:0] S_BE3 = 4'd13;
	localparam logic [3:0] S_BE4 = 4'd14;

	localparam logic [1:0] SW_RESET = 2'd0;
	localparam logic [1:0] SW_CLEAR = 2'd1;
	localparam logic [1:0] SW_ALLOC = 2'd2;

	typedef logic [NW-1:0] node_t;

	// memories
	node_t trans_mem_q [TDEPTH];
	node_t fail_mem_q [NODE_POOL];
	node_t outl_mem_q [NODE_POOL];
	tag_t tag_mem_q [NODE_POOL];
	node_t queue_mem_q [NODE_POOL];
	node_t trans_rd_q, fail_rd_q, outl_rd_q, queue_rd_q;
	tag_t tag_rd_q;

	logic trans_re, trans_we, node_re, tag_we, fail_we, outl_we, q_re, q_we;
	logic [TAW-1:0] trans_raddr, trans_waddr;
	node_t trans_wdata, node_raddr, node_waddr, fail_wdata, outl_wdata, q_raddr, q_waddr;
	node_t q_wdata;
	tag_t tag_wdata;

	// control state
	logic [3:0] state_q, state_d;
	char_t cnt_q, cnt_d;
	logic [1:0] sw_mode_q, sw_mode_d;
	logic [CW-1:0] nodes_q, nodes_d;
	node_t cur_q, cur_d, scan_q, scan_d, head_q, head_d, tail_q, tail_d;
	logic [LW-1:0] len_q, len_d;
	logic open_q, open_d, bad_q, bad_d, built_q, built_d, pend_v_q, pend_v_d;
	pos_t pos_q, pos_d;
	logic out_v_q;

	// payload
	node_t sw_node_q, sw_node_d, child_q, child_d, u_q, u_d, f_q, f_d, v_q, v_d, w_q, w_d;
	tag_t sw_tag_q, sw_tag_d;
	char_t c_q, c_d;
	kw_id_t id_q, id_d, pend_id_q, pend_id_d;
	logic last_q, last_d;
	status_t resp_st_q, resp_st_d;
	status_t out_st_q;
	kw_id_t out_id_q;
	pos_t out_pos_q;
	logic out_fin_q;

	logic out_free, push, push_fin;
	status_t push_st;
	kw_id_t push_id;
	pos_t push_pos;
	logic k_open;
	node_t t_node;

	assign out_free = !out_v_q || rsp.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.status = out_st_q;
	assign rsp.match_id = out_id_q;
	assign rsp.end_position = out_pos_q;
	assign rsp.final_result = out_fin_q;

	always_comb begin
		state_d = state_q; cnt_d = cnt_q; sw_mode_d = sw_mode_q; nodes_d = nodes_q;
		cur_d = cur_q; scan_d = scan_q; head_d = head_q; tail_d = tail_q; len_d = len_q;
		open_d = open_q; bad_d = bad_q; built_d = built_q; pend_v_d = pend_v_q; pos_d = pos_q;
		sw_node_d = sw_node_q; child_d = child_q; u_d = u_q; f_d = f_q; v_d = v_q; w_d = w_q;
		sw_tag_d = sw_tag_q; c_d = c_q; id_d = id_q; pend_id_d = pend_id_q; last_d = last_q;
		resp_st_d = resp_st_q;
		trans_re = 1'b0; trans_we = 1'b0; node_re = 1'b0; tag_we = 1'b0; fail_we = 1'b0;
		outl_we = 1'b0; q_re = 1'b0; q_we = 1'b0;
		trans_raddr = '0; trans_waddr = '0; trans_wdata = '0; node_raddr = '0; node_waddr = '0;
		fail_wdata = '0; outl_wdata = '0; q_raddr = '0; q_waddr = '0; q_wdata = '0;
		tag_wdata = '0;
		push = 1'b0; push_st = ST_OK; push_id = '0; push_pos = '0; push_fin = 1'b1;
		k_open = 1'b0; t_node = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					c_d = cmd.data_byte;
					id_d = cmd.keyword_id;
					last_d = cmd.last;
					unique case (cmd.kind)
						KIND_CLEAR: begin
							nodes_d = CW'(1); cur_d = '0; scan_d = '0; pos_d = '0;
							built_d = 1'b0; len_d = '0; open_d = 1'b0; bad_d = 1'b0;
							sw_node_d = '0; sw_tag_d = '0; sw_mode_d = SW_CLEAR; cnt_d = '0;
							state_d = S_SWEEP;
						end
						KIND_KEYWORD: begin
							resp_st_d = ST_REJECT;
							state_d = S_RESP;
							k_open = cmd.first | open_q;
							if (!built_q && k_open) begin
								open_d = !cmd.last;
								bad_d = cmd.first ? 1'b0 : bad_q;
								len_d = cmd.first ? '0 : len_q;
								cur_d = cmd.first ? '0 : cur_q;
								if (!bad_d) begin
									if (len_d >= MAX_LEN) begin
										bad_d = 1'b1;
									end else begin
										trans_re = 1'b1;
										trans_raddr = {cur_d, cmd.data_byte};
										state_d = S_KDAT;
									end
								end
							end
						end
						KIND_BUILD: begin
							if (built_q) begin
								resp_st_d = ST_OK;
								state_d = S_RESP;
							end else begin
								open_d = 1'b0; head_d = '0; tail_d = '0; cnt_d = '0;
								trans_re = 1'b1;
								trans_raddr = '0;
								state_d = S_R0;
							end
						end
						KIND_TEXT: begin
							if (!built_q) begin
								resp_st_d = ST_REJECT;
								state_d = S_RESP;
							end else begin
								t_node = cmd.first ? '0 : scan_q;
								pos_d = (cmd.first ? '0 : pos_q) + POS_W'(1);
								trans_re = 1'b1;
								trans_raddr = {t_node, cmd.data_byte};
								state_d = S_TDAT;
							end
						end
						default: ;
					endcase
				end
			end
			S_KDAT: begin
				state_d = S_RESP;
				resp_st_d = ST_OK;
				if (trans_rd_q != '0) begin
					cur_d = trans_rd_q;
					len_d = len_q + LW'(1);
					if (last_q) begin
						tag_we = 1'b1;
						node_waddr = trans_rd_q;
						tag_wdata = {1'b1, id_q};
					end
				end else if (nodes_q >= POOL_CNT) begin
					bad_d = 1'b1;
					resp_st_d = ST_REJECT;
				end else begin
					child_d = nodes_q[NW-1:0];
					nodes_d = nodes_q + CW'(1);
					sw_node_d = nodes_q[NW-1:0];
					sw_tag_d = last_q ? {1'b1, id_q} : '0;
					sw_mode_d = SW_ALLOC;
					cnt_d = '0;
					state_d = S_SWEEP;
				end
			end
			S_SWEEP: begin
				trans_we = 1'b1;
				trans_waddr = {sw_node_q, cnt_q};
				if (cnt_q == '0) begin
					tag_we = 1'b1; fail_we = 1'b1; outl_we = 1'b1;
					node_waddr = sw_node_q;
					tag_wdata = sw_tag_q;
				end
				cnt_d = cnt_q + CHAR_W'(1);
				if (cnt_q == LAST_CHAR) begin
					unique case (sw_mode_q)
						SW_CLEAR: begin
							resp_st_d = ST_OK;
							state_d = S_RESP;
						end
						SW_ALLOC: state_d = S_KLINK;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_KLINK: begin
				trans_we = 1'b1;
				trans_waddr = {cur_q, c_q};
				trans_wdata = child_q;
				cur_d = child_q;
				len_d = len_q + LW'(1);
				resp_st_d = ST_OK;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					push = 1'b1;
					push_st = resp_st_q;
					state_d = S_IDLE;
				end
			end
			S_TDAT: begin
				scan_d = trans_rd_q;
				if (trans_rd_q == '0) begin
					state_d = S_FIN;
				end else begin
					node_re = 1'b1;
					node_raddr = trans_rd_q;
					state_d = S_TCH;
				end
			end
			S_TCH: begin
				if (!(tag_rd_q[TAG_W-1] && pend_v_q && !out_free)) begin
					if (tag_rd_q[TAG_W-1]) begin
						if (pend_v_q) begin
							push = 1'b1; push_st = ST_MATCH; push_id = pend_id_q;
							push_pos = pos_q; push_fin = 1'b0;
						end
						pend_v_d = 1'b1;
						pend_id_d = tag_rd_q[ID_W-1:0];
					end
					if (outl_rd_q == '0) begin
						state_d = S_FIN;
					end else begin
						node_re = 1'b1;
						node_raddr = outl_rd_q;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					push = 1'b1;
					push_st = pend_v_q ? ST_MATCH : ST_OK;
					push_id = pend_v_q ? pend_id_q : '0;
					push_pos = pos_q;
					pend_v_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			S_R0: begin
				if (trans_rd_q != '0) begin
					q_we = 1'b1; q_waddr = tail_q; q_wdata = trans_rd_q;
					tail_d = tail_q + NW'(1);
				end
				if (cnt_q == LAST_CHAR) begin
					state_d = S_POP;
				end else begin
					cnt_d = cnt_q + CHAR_W'(1);
					trans_re = 1'b1;
					trans_raddr = {node_t'(0), cnt_d};
				end
			end
			S_POP: begin
				if (head_q == tail_q) begin
					built_d = 1'b1;
					resp_st_d = ST_OK;
					state_d = S_RESP;
				end else begin
					q_re = 1'b1; q_raddr = head_q;
					head_d = head_q + NW'(1);
					state_d = S_BU;
				end
			end
			S_BU: begin
				u_d = queue_rd_q;
				node_re = 1'b1; node_raddr = queue_rd_q;
				state_d = S_BF;
			end
			S_BF: begin
				f_d = fail_rd_q;
				cnt_d = '0;
				trans_re = 1'b1; trans_raddr = {u_q, char_t'(0)};
				state_d = S_BE2;
			end
			S_BE2: begin
				v_d = trans_rd_q;
				trans_re = 1'b1; trans_raddr = {f_q, cnt_q};
				state_d = S_BE3;
			end
			S_BE3, S_BE4: begin
				if (state_q == S_BE3 && v_q != '0) begin
					w_d = trans_rd_q;
					fail_we = 1'b1; node_waddr = v_q; fail_wdata = trans_rd_q;
					node_re = 1'b1; node_raddr = trans_rd_q;
					state_d = S_BE4;
				end else begin
					if (state_q == S_BE3) begin
						trans_we = 1'b1; trans_waddr = {u_q, cnt_q}; trans_wdata = trans_rd_q;
					end else begin
						outl_we = 1'b1; node_waddr = v_q;
						outl_wdata = tag_rd_q[TAG_W-1] ? w_q : outl_rd_q;
						q_we = 1'b1; q_waddr = tail_q; q_wdata = v_q;
						tail_d = tail_q + NW'(1);
					end
					if (cnt_q == LAST_CHAR) begin
						state_d = S_POP;
					end else begin
						cnt_d = cnt_q + CHAR_W'(1);
						trans_re = 1'b1; trans_raddr = {u_q, cnt_d};
						state_d = S_BE2;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (trans_we) trans_mem_q[trans_waddr] <= trans_wdata;
		if (trans_re) trans_rd_q <= trans_mem_q[trans_raddr];
	end

	always_ff @(posedge clk) begin
		if (tag_we) tag_mem_q[node_waddr] <= tag_wdata;
		if (fail_we) fail_mem_q[node_waddr] <= fail_wdata;
		if (outl_we) outl_mem_q[node_waddr] <= outl_wdata;
		if (node_re) begin
			tag_rd_q <= tag_mem_q[node_raddr];
			fail_rd_q <= fail_mem_q[node_raddr];
			outl_rd_q <= outl_mem_q[node_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_we) queue_mem_q[q_waddr] <= q_wdata;
		if (q_re) queue_rd_q <= queue_mem_q[q_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP; cnt_q <= '0; sw_mode_q <= SW_RESET; nodes_q <= CW'(1);
			cur_q <= '0; scan_q <= '0; head_q <= '0; tail_q <= '0; len_q <= '0;
			open_q <= 1'b0; bad_q <= 1'b0; built_q <= 1'b0; pend_v_q <= 1'b0; pos_q <= '0;
			out_v_q <= 1'b0; sw_node_q <= '0; sw_tag_q <= '0;
		end else begin
			state_q <= state_d; cnt_q <= cnt_d; sw_mode_q <= sw_mode_d; nodes_q <= nodes_d;
			cur_q <= cur_d; scan_q <= scan_d; head_q <= head_d; tail_q <= tail_d;
			len_q <= len_d; open_q <= open_d; bad_q <= bad_d; built_q <= built_d;
			pend_v_q <= pend_v_d; pos_q <= pos_d;
			sw_node_q <= sw_node_d; sw_tag_q <= sw_tag_d;
			if (push) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		child_q <= child_d; u_q <= u_d; f_q <= f_d; v_q <= v_d; w_q <= w_d;
		c_q <= c_d; id_q <= id_d; pend_id_q <= pend_id_d; last_q <= last_d;
		resp_st_q <= resp_st_d;
		if (push) begin
			out_st_q <= push_st; out_id_q <= push_id; out_pos_q <= push_pos;
			out_fin_q <= push_fin;
		end
	end

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nodes_q <= POOL_CNT) else $error("node count beyond pool");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= MAX_LEN) else $error("keyword length beyond limit");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free) else $error("response register overwritten");
	a_text_unbuilt: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && cmd.kind == KIND_TEXT && !built_q)
		|=> (state_q == S_RESP && resp_st_q == ST_REJECT))
		else $error("text request before build not rejected");
endmodule
`default_nettype wire
